[hdl/smseq_pkg.sv]
package smseq_pkg;

    localparam int TABLE_LEN   = 16;
    localparam int PERIOD_BITS = 24;
    localparam int IDX_W       = $clog2(TABLE_LEN);

    localparam int NUM_W     = 24;
    localparam int DEN_W     = 12;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [31:0] PERIOD_MAX = 32'((64'd1 << PERIOD_BITS) - 64'd1);

    localparam logic [1:0] CFG_TICK_RATE    = 2'd0;
    localparam logic [1:0] CFG_BASE_RATE    = 2'd1;
    localparam logic [1:0] CFG_RATE_STEP    = 2'd2;
    localparam logic [1:0] CFG_SPEED_LEVELS = 2'd3;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_KEY  = 1'b1;

    localparam logic [2:0] KEY_RUN     = 3'd0;
    localparam logic [2:0] KEY_FULL    = 3'd1;
    localparam logic [2:0] KEY_HALF    = 3'd2;
    localparam logic [2:0] KEY_QUARTER = 3'd3;
    localparam logic [2:0] KEY_REVERSE = 3'd4;
    localparam logic [2:0] KEY_FASTER  = 3'd5;
    localparam logic [2:0] KEY_SLOWER  = 3'd6;

    localparam logic [1:0] KIND_FULL    = 2'd0;
    localparam logic [1:0] KIND_HALF    = 2'd1;
    localparam logic [1:0] KIND_QUARTER = 2'd2;

    localparam logic [7:0] TAB_FULL [16] = '{
        8'h61, 8'h41, 8'h01, 8'h21, 8'h61, 8'h41, 8'h01, 8'h21,
        8'h61, 8'h41, 8'h01, 8'h21, 8'h61, 8'h41, 8'h01, 8'h21};
    localparam logic [7:0] TAB_HALF [16] = '{
        8'h6B, 8'h67, 8'h4B, 8'h59, 8'h0B, 8'h07, 8'h2B, 8'h39,
        8'h6B, 8'h67, 8'h4B, 8'h59, 8'h0B, 8'h07, 8'h2B, 8'h39};
    localparam logic [7:0] TAB_QUARTER [16] = '{
        8'h71, 8'h6B, 8'h65, 8'h67, 8'h45, 8'h4B, 8'h51, 8'h59,
        8'h11, 8'h0B, 8'h05, 8'h07, 8'h25, 8'h2B, 8'h31, 8'h39};

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

[hdl/smseq_div.sv]
module smseq_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smseq_pkg::t_div_req i_req,
    output smseq_pkg::t_div_rsp o_rsp
);
    import smseq_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0]     r_rem, n_rem;
    logic [NUM_W-1:0]     r_quo, n_quo;
    logic [DEN_W-1:0]     r_den, n_den;
    logic [DEN_W:0]       w_shift;
    logic [DEN_W:0]       w_diff;
    logic                 w_fits;

    // restoring step: one quotient bit per cycle, numerator shifts out of r_quo
    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_fits  = (w_shift >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.num;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem = w_fits ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], w_fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

endmodule

[hdl/stepper_microstep_sequencer_top.sv]
// A key beat or a tick that fires no step goes from S_IDLE to S_OUT, and its result
// is loaded into the output register once that register is free. A tick that fires a step
// first waits in S_DIV for the period division, one quotient bit per cycle over 24 bits.
// One beat in flight; a new beat is taken once the result is in the output register.
// Reset (i_rst_n low, synchronous) restores the register defaults and the idle state.
module stepper_microstep_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [2:0]  i_key,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_coil_pattern,
    output logic        o_step_fired,
    output logic        o_running,
    output logic [1:0]  o_microstep_kind,
    output logic        o_clockwise,
    output logic [6:0]  o_speed_level,
    output logic [11:0] o_step_rate
);
    import smseq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [23:0]            r_tick_rate;
    logic [7:0]             r_base_rate;
    logic [3:0]             r_rate_step;
    logic [7:0]             r_speed_levels;
    logic [IDX_W-1:0]       r_phase, n_phase;
    logic [1:0]             r_kind, n_kind;
    logic                   r_dir, n_dir;
    logic                   r_run, n_run;
    logic [6:0]             r_speed, n_speed;
    logic [PERIOD_BITS-1:0] r_period, n_period;
    logic [PERIOD_BITS-1:0] r_tick, n_tick;
    logic [7:0]             r_port, n_port;
    logic                   r_fired, n_fired;
    logic                   r_ovalid;

    logic                   w_accept;
    logic                   w_fire;
    logic [11:0]            w_rate;
    logic [7:0]             w_smax;
    logic [7:0]             w_speed_inc;
    logic [3:0]             w_tab_idx;
    logic [31:0]            w_quo32;
    logic                   w_out_free;
    t_div_req               w_req;
    t_div_rsp               w_rsp;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;

    assign w_rate      = 12'(r_base_rate) + 12'(r_rate_step) * 12'(r_speed);
    assign w_smax      = (r_speed_levels == 8'd0) ? 8'd0
                       : (r_speed_levels > 8'd128) ? 8'd127 : r_speed_levels - 8'd1;
    assign w_speed_inc = {1'b0, r_speed} + 8'd1;
    assign w_tab_idx   = 4'(r_phase);
    assign w_quo32     = 32'(w_rsp.quo);

    assign w_fire = (i_mode == MODE_TICK) && r_run
                 && ({1'b0, r_tick} + 1'b1 >= {1'b0, r_period});

    assign w_req.start = w_accept && w_fire;
    assign w_req.num   = r_tick_rate;
    assign w_req.den   = w_rate;

    smseq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_dir    = r_dir;
        n_run    = r_run;
        n_speed  = r_speed;
        n_period = r_period;
        n_tick   = r_tick;
        n_port   = r_port;
        n_fired  = r_fired;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_fired = w_fire;
                    n_state = w_fire ? S_DIV : S_OUT;
                    if (i_mode == MODE_TICK) begin
                        if (w_fire) begin
                            n_tick = '0;
                            unique case (r_kind)
                                KIND_FULL:    n_port = TAB_FULL[w_tab_idx];
                                KIND_HALF:    n_port = TAB_HALF[w_tab_idx];
                                KIND_QUARTER: n_port = TAB_QUARTER[w_tab_idx];
                                default:      n_port = r_port;
                            endcase
                            if (r_dir) begin
                                n_phase = (r_phase == '0) ? IDX_W'(TABLE_LEN - 1)
                                                          : r_phase - 1'b1;
                            end else begin
                                n_phase = (r_phase == IDX_W'(TABLE_LEN - 1)) ? '0
                                                                             : r_phase + 1'b1;
                            end
                        end else if (r_run) begin
                            n_tick = r_tick + 1'b1;
                        end
                    end else begin
                        unique case (i_key)
                            KEY_RUN: begin
                                n_run = !r_run;
                                if (!r_run) begin
                                    n_port  = r_port | 8'h01;
                                    n_speed = '0;
                                end else begin
                                    n_port = r_port & 8'hFE;
                                end
                            end
                            KEY_FULL, KEY_HALF, KEY_QUARTER: begin
                                if (!r_run) n_kind = 2'(i_key - KEY_FULL);
                            end
                            KEY_REVERSE: n_dir = !r_dir;
                            KEY_FASTER: begin
                                if (r_run) begin
                                    n_speed = (w_speed_inc > w_smax) ? 7'(w_smax)
                                                                     : 7'(w_speed_inc);
                                end
                            end
                            KEY_SLOWER: begin
                                if (r_run && r_speed != '0) n_speed = r_speed - 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    // zero divisor and oversized quotients clamp to the longest period
                    if (w_rate == '0) begin
                        n_period = PERIOD_BITS'(PERIOD_MAX);
                    end else begin
                        n_period = PERIOD_BITS'((w_quo32 > PERIOD_MAX) ? PERIOD_MAX
                                                                        : w_quo32);
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_tick_rate    <= 24'd1000000;
            r_base_rate    <= 8'd24;
            r_rate_step    <= 4'd3;
            r_speed_levels <= 8'd100;
            r_phase        <= IDX_W'(TABLE_LEN - 1);
            r_kind         <= KIND_FULL;
            r_dir          <= 1'b1;
            r_run          <= 1'b0;
            r_speed        <= '0;
            r_period       <= PERIOD_BITS'(41666);
            r_tick         <= '0;
            r_port         <= '0;
            r_fired        <= 1'b0;
            r_ovalid       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_dir    <= n_dir;
            r_run    <= n_run;
            r_speed  <= n_speed;
            r_period <= n_period;
            r_tick   <= n_tick;
            r_port   <= n_port;
            r_fired  <= n_fired;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TICK_RATE:    r_tick_rate    <= i_cfg_data;
                    CFG_BASE_RATE:    r_base_rate    <= i_cfg_data[7:0];
                    CFG_RATE_STEP:    r_rate_step    <= i_cfg_data[3:0];
                    CFG_SPEED_LEVELS: r_speed_levels <= i_cfg_data[7:0];
                endcase
            end
            // load the result beat once the output register is free, else drop a taken beat
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            o_coil_pattern   <= r_port;
            o_step_fired     <= r_fired;
            o_running        <= r_run;
            o_microstep_kind <= r_kind;
            o_clockwise      <= r_dir;
            o_speed_level    <= r_speed;
            o_step_rate      <= r_run ? w_rate : 12'd0;
        end
    end

    assign o_valid = r_ovalid;

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_rsp.busy || w_rsp.done))
        else $error("waiting on a divider that is not running");

    a_fire_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_step_fired) |-> o_running)
        else $error("step fired while paused");

    a_paused_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_running) |-> (!o_coil_pattern[0] && o_step_rate == 12'd0))
        else $error("paused beat shows drive enable or step rate");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("second beat taken before result was produced");

endmodule

[tb/sv/stepper_microstep_sequencer_top_tb.sv]
module stepper_microstep_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smseq_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam int          DRAIN_CYCLES = 30;
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam logic [2:0]  KEY_UNUSED   = 3'd7;

    typedef struct packed {
        logic [7:0]  coil;
        logic        fired;
        logic        running;
        logic [1:0]  kind;
        logic        cw;
        logic [6:0]  speed;
        logic [11:0] rate;
    } drive_state_t;

    typedef struct packed {
        logic         mode;
        logic [2:0]   key;
        logic         typed;
        drive_state_t want;
    } stim_row_t;

    localparam logic [7:0] FULL_SEQ [4]     = '{8'h61, 8'h41, 8'h01, 8'h21};
    localparam logic [7:0] HALF_SEQ [8]     = '{8'h6B, 8'h67, 8'h4B, 8'h59,
                                                8'h0B, 8'h07, 8'h2B, 8'h39};
    localparam logic [7:0] QUARTER_SEQ [16] = '{8'h71, 8'h6B, 8'h65, 8'h67,
                                                8'h45, 8'h4B, 8'h51, 8'h59,
                                                8'h11, 8'h0B, 8'h05, 8'h07,
                                                8'h25, 8'h2B, 8'h31, 8'h39};

    // Walked right after reset with the default settings.
    localparam int DIR_ROWS = 24;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{MODE_TICK, KEY_RUN,     1'b1, '{8'h00, 1'b0, 1'b0, KIND_FULL,    1'b1, 7'd0, 12'd0}},
        '{MODE_KEY,  KEY_FASTER,  1'b1, '{8'h00, 1'b0, 1'b0, KIND_FULL,    1'b1, 7'd0, 12'd0}},
        '{MODE_KEY,  KEY_SLOWER,  1'b1, '{8'h00, 1'b0, 1'b0, KIND_FULL,    1'b1, 7'd0, 12'd0}},
        '{MODE_KEY,  KEY_HALF,    1'b1, '{8'h00, 1'b0, 1'b0, KIND_HALF,    1'b1, 7'd0, 12'd0}},
        '{MODE_KEY,  KEY_QUARTER, 1'b1, '{8'h00, 1'b0, 1'b0, KIND_QUARTER, 1'b1, 7'd0, 12'd0}},
        '{MODE_KEY,  KEY_UNUSED,  1'b1, '{8'h00, 1'b0, 1'b0, KIND_QUARTER, 1'b1, 7'd0, 12'd0}},
        '{MODE_KEY,  KEY_FULL,    1'b1, '{8'h00, 1'b0, 1'b0, KIND_FULL,    1'b1, 7'd0, 12'd0}},
        '{MODE_KEY,  KEY_REVERSE, 1'b1, '{8'h00, 1'b0, 1'b0, KIND_FULL,    1'b0, 7'd0, 12'd0}},
        '{MODE_KEY,  KEY_REVERSE, 1'b1, '{8'h00, 1'b0, 1'b0, KIND_FULL,    1'b1, 7'd0, 12'd0}},
        '{MODE_KEY,  KEY_RUN,     1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b1, 7'd0, 12'd24}},
        '{MODE_KEY,  KEY_HALF,    1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b1, 7'd0, 12'd24}},
        '{MODE_KEY,  KEY_FASTER,  1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b1, 7'd1, 12'd27}},
        '{MODE_KEY,  KEY_FASTER,  1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b1, 7'd2, 12'd30}},
        '{MODE_KEY,  KEY_SLOWER,  1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b1, 7'd1, 12'd27}},
        '{MODE_KEY,  KEY_SLOWER,  1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b1, 7'd0, 12'd24}},
        '{MODE_KEY,  KEY_SLOWER,  1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b1, 7'd0, 12'd24}},
        '{MODE_TICK, KEY_UNUSED,  1'b0, '0},
        '{MODE_KEY,  KEY_UNUSED,  1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b1, 7'd0, 12'd24}},
        '{MODE_KEY,  KEY_REVERSE, 1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b0, 7'd0, 12'd24}},
        '{MODE_KEY,  KEY_FASTER,  1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b0, 7'd1, 12'd27}},
        '{MODE_KEY,  KEY_RUN,     1'b1, '{8'h00, 1'b0, 1'b0, KIND_FULL,    1'b0, 7'd1, 12'd0}},
        '{MODE_TICK, KEY_SLOWER,  1'b0, '0},
        '{MODE_KEY,  KEY_RUN,     1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b0, 7'd0, 12'd24}},
        '{MODE_KEY,  KEY_REVERSE, 1'b1, '{8'h01, 1'b0, 1'b1, KIND_FULL,    1'b1, 7'd0, 12'd24}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_mode;
    logic [2:0]  i_key;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_coil_pattern;
    logic        o_step_fired;
    logic        o_running;
    logic [1:0]  o_microstep_kind;
    logic        o_clockwise;
    logic [6:0]  o_speed_level;
    logic [11:0] o_step_rate;

    stepper_microstep_sequencer_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_key            (i_key),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_coil_pattern   (o_coil_pattern),
        .o_step_fired     (o_step_fired),
        .o_running        (o_running),
        .o_microstep_kind (o_microstep_kind),
        .o_clockwise      (o_clockwise),
        .o_speed_level    (o_speed_level),
        .o_step_rate      (o_step_rate)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Motor state as the block should hold it
    logic [23:0] m_tick_rate;
    logic [7:0]  m_base_rate;
    logic [3:0]  m_rate_step;
    logic [7:0]  m_speed_levels;
    logic [3:0]  m_phase;
    logic [1:0]  m_kind;
    logic        m_cw;
    logic        m_run;
    logic [6:0]  m_speed;
    logic [23:0] m_period;
    logic [23:0] m_ticks;
    logic [7:0]  m_port;

    drive_state_t pending_drive [$];
    int unsigned  cycle_count    = 0;
    int           mismatch_count = 0;
    int           beats_sent     = 0;
    int           steps_fired    = 0;
    int           settings_used  = 0;
    logic         no_idle        = 1'b0;
    int           sink_left      = 0;
    logic         sink_on        = 1'b1;

    function automatic drive_state_t next_drive_state(logic mode, logic [2:0] key);
        int unsigned divisor;
        int unsigned quot;
        int unsigned cap;
        logic        fired;
        fired = 1'b0;
        if (mode == MODE_TICK) begin
            if (m_run) begin
                if (m_ticks + 1 >= m_period) begin
                    m_ticks = '0;
                    fired   = 1'b1;
                    divisor = m_base_rate + m_rate_step * m_speed;
                    quot    = (divisor == 0) ? PERIOD_MAX : m_tick_rate / divisor;
                    if (quot > PERIOD_MAX) quot = PERIOD_MAX;
                    m_period = 24'(quot);
                    case (m_kind)
                        KIND_FULL:    m_port = FULL_SEQ[m_phase[1:0]];
                        KIND_HALF:    m_port = HALF_SEQ[m_phase[2:0]];
                        KIND_QUARTER: m_port = QUARTER_SEQ[m_phase];
                        default:      m_port = m_port;
                    endcase
                    // 4-bit index wraps across the 16-entry table on its own
                    m_phase = m_cw ? m_phase - 4'd1 : m_phase + 4'd1;
                end else begin
                    m_ticks = m_ticks + 24'd1;
                end
            end
        end else begin
            case (key)
                KEY_RUN: begin
                    m_run = ~m_run;
                    if (m_run) begin
                        m_port[0] = 1'b1;
                        m_speed   = '0;
                    end else begin
                        m_port[0] = 1'b0;
                    end
                end
                KEY_FULL:    if (!m_run) m_kind = KIND_FULL;
                KEY_HALF:    if (!m_run) m_kind = KIND_HALF;
                KEY_QUARTER: if (!m_run) m_kind = KIND_QUARTER;
                KEY_REVERSE: m_cw = ~m_cw;
                KEY_FASTER: begin
                    if (m_run) begin
                        cap = (m_speed_levels == 0) ? 0 : m_speed_levels - 1;
                        if (cap > 127) cap = 127;
                        // a lowered level count pulls a higher speed down to the cap
                        m_speed = (m_speed + 1 > cap) ? 7'(cap) : m_speed + 7'd1;
                    end
                end
                KEY_SLOWER: if (m_run && m_speed != 0) m_speed = m_speed - 7'd1;
                default: ;
            endcase
        end
        return '{coil: m_port, fired: fired, running: m_run, kind: m_kind, cw: m_cw,
                 speed: m_speed,
                 rate: m_run ? 12'(m_base_rate) + 12'(m_rate_step) * 12'(m_speed)
                             : 12'd0};
    endfunction

    task automatic send_beat(logic mode, logic [2:0] key, logic typed, drive_state_t want);
        drive_state_t seen;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_key   <= key;
        do @(posedge i_clk); while (!o_ready);
        seen = next_drive_state(mode, key);
        pending_drive.push_back(typed ? want : seen);
        beats_sent++;
        if (seen.fired) steps_fired++;
        @(negedge i_clk);
    endtask

    // Call at a falling edge with no beat outstanding on the input side
    task automatic drain_results();
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic put_reg(logic [1:0] idx, logic [23:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic load_settings(logic [23:0] tr, logic [7:0] br, logic [3:0] rs,
                                 logic [7:0] sl);
        i_valid <= 1'b0;
        drain_results();
        put_reg(CFG_TICK_RATE, tr);
        put_reg(CFG_BASE_RATE, 24'(br));
        put_reg(CFG_RATE_STEP, 24'(rs));
        put_reg(CFG_SPEED_LEVELS, 24'(sl));
        @(negedge i_clk);
        i_cfg_we       <= 1'b0;
        m_tick_rate    = tr;
        m_base_rate    = br;
        m_rate_step    = rs;
        m_speed_levels = sl;
        settings_used++;
    endtask

    // speed_push keeps a running motor off ticks so no step reloads a huge period
    task automatic run_phase(int beats, logic speed_push);
        logic       mode;
        logic [2:0] key;
        int         pick;
        for (int n = 0; n < beats; n++) begin
            if (n == beats / 2) begin
                i_valid <= 1'b0;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            mode = MODE_KEY;
            key  = 3'($urandom_range(0, 7));
            if (m_run && speed_push) begin
                if (pick < 70)      key = KEY_FASTER;
                else if (pick < 76) key = KEY_SLOWER;
                else if (pick < 84) key = KEY_REVERSE;
                else if (pick < 94) key = 3'($urandom_range(KEY_FULL, KEY_QUARTER));
                else if (pick < 97) key = KEY_UNUSED;
                else                key = KEY_RUN;
            end else if (m_run) begin
                if (pick < 60)      mode = MODE_TICK;
                else if (pick < 63) key = KEY_RUN;
                else if (pick < 70) key = 3'($urandom_range(KEY_FULL, KEY_QUARTER));
                else if (pick < 77) key = KEY_REVERSE;
                else if (pick < 88) key = KEY_FASTER;
                else if (pick < 96) key = KEY_SLOWER;
                else                key = KEY_UNUSED;
            end else begin
                if (pick < 30)      mode = MODE_TICK;
                else if (pick < 60) key = KEY_RUN;
                else if (pick < 78) key = 3'($urandom_range(KEY_FULL, KEY_QUARTER));
                else if (pick < 85) key = KEY_REVERSE;
                else if (pick < 90) key = KEY_FASTER;
                else if (pick < 95) key = KEY_SLOWER;
                else                key = KEY_UNUSED;
            end
            send_beat(mode, key, 1'b0, '0);
        end
        i_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (sink_left == 0) begin
            sink_on   = no_idle || ($urandom_range(0, 2) != 0);
            sink_left = $urandom_range(1, 16);
        end
        sink_left = sink_left - 1;
        i_ready <= sink_on || no_idle;
    end

    always @(posedge i_clk) begin
        drive_state_t got;
        drive_state_t want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{coil: o_coil_pattern, fired: o_step_fired, running: o_running,
                    kind: o_microstep_kind, cw: o_clockwise, speed: o_speed_level,
                    rate: o_step_rate};
            if (pending_drive.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result coil=%h fired=%b run=%b kind=%0d cw=%b",
                         $time, got.coil, got.fired, got.running, got.kind, got.cw,
                         " speed=%0d rate=%0d", got.speed, got.rate);
            end else begin
                want = pending_drive.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    $display({"%0t: expected coil=%h fired=%b run=%b kind=%0d cw=%b ",
                              "speed=%0d rate=%0d, got coil=%h fired=%b run=%b ",
                              "kind=%0d cw=%b speed=%0d rate=%0d"},
                             $time, want.coil, want.fired, want.running, want.kind,
                             want.cw, want.speed, want.rate, got.coil, got.fired,
                             got.running, got.kind, got.cw, got.speed, got.rate);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_drive.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int walk_start;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_mode     = MODE_TICK;
        i_key      = KEY_RUN;
        i_ready    = 1'b0;

        m_tick_rate    = 24'd1000000;
        m_base_rate    = 8'd24;
        m_rate_step    = 4'd3;
        m_speed_levels = 8'd100;
        m_phase        = 4'd15;
        m_kind         = KIND_FULL;
        m_cw           = 1'b1;
        m_run          = 1'b0;
        m_speed        = '0;
        m_period       = 24'd41666;
        m_ticks        = '0;
        m_port         = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(DIRECTED[i].mode, DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].want);

        // The reset period only gives way after the first step; walk ticks up to it
        // with a small tick rate so that later periods stay short.
        load_settings(24'd40, 8'd24, 4'd3, 8'd100);
        no_idle = 1'b1;
        if (!m_run) send_beat(MODE_KEY, KEY_RUN, 1'b0, '0);
        walk_start = steps_fired;
        while (steps_fired == walk_start)
            send_beat(MODE_TICK, 3'($urandom_range(0, 7)), 1'b0, '0);
        no_idle = 1'b0;
        run_phase(40, 1'b0);

        load_settings(24'd16000000, 8'd255, 4'd15, 8'd128);
        run_phase(150, 1'b1);

        load_settings(24'd1, 8'd1, 4'd0, 8'd1);
        run_phase(200, 1'b0);

        repeat (4) begin
            load_settings(24'($urandom_range(1, 300)), 8'($urandom_range(1, 255)),
                          4'($urandom_range(0, 15)), 8'($urandom_range(1, 128)));
            run_phase(200, 1'b0);
        end

        load_settings(24'($urandom_range(1, 60)), 8'($urandom_range(1, 40)),
                      4'($urandom_range(0, 15)), 8'($urandom_range(1, 128)));
        no_idle = 1'b1;
        run_phase(150, 1'b0);

        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats over %0d register settings; %0d of them fired a step.",
                 beats_sent, settings_used + 1, steps_fired);
        $display("Mismatching results: %0d", mismatch_count);
        if (mismatch_count == 0 && pending_drive.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/smseq_pkg.sv
hdl/smseq_div.sv
hdl/stepper_microstep_sequencer_top.sv
tb/sv/stepper_microstep_sequencer_top_tb.sv
